// ===== src/quantized_mlp_inference_core_defines.svh =====
// Assertion macros shared by the RTL of the quantized MLP inference core.
// No dependencies; compiled out when ASSERT_OFF is defined.
`ifndef QUANTIZED_MLP_INFERENCE_CORE_DEFINES_SVH
`define QUANTIZED_MLP_INFERENCE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define QMI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QMI_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define QMI_ASSERT(label, clk, rst_n, prop, msg)
`define QMI_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/qmi_pkg.sv =====
// Shared types, constants and the rounding scaler for the MLP inference core.
// No dependencies.
package qmi_pkg;
  localparam int unsigned InputCount  = 16;
  localparam int unsigned HiddenCount = 16;
  localparam int unsigned InW = $clog2(InputCount);
  localparam int unsigned HidW = $clog2(HiddenCount);
  localparam int unsigned WtAddrW = $clog2(InputCount * HiddenCount);
  localparam logic [6:0] RoundBase = 7'd30;
  localparam logic [2:0] ActMax = 3'd7;

  typedef enum logic [1:0] {
    REQ_HID_WEIGHT = 2'd0,
    REQ_HID_PARAM  = 2'd1,
    REQ_OUT_WEIGHT = 2'd2,
    REQ_SAMPLE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_OUT_BIAS = 2'd0,
    REG_OUT_MULT = 2'd1,
    REG_OUT_SHIFT = 2'd2
  } reg_e;

  // Control handed down the cell row
  typedef struct packed {
    logic            valid;
    logic            first;
    logic [InW-1:0]  idx;
  } mac_ctl_t;

  // Round and shift a 64-bit product: (p + 2^(30+s)) >>> (31+s), low 32 bits
  function automatic logic [31:0] round_shift(input logic signed [63:0] p,
                                              input logic [4:0] s);
    logic signed [63:0] t;
    logic signed [63:0] r;
    t = p + (64'sd1 <<< (RoundBase + 7'(s)));
    r = t >>> (7'd31 + 7'(s));
    return r[31:0];
  endfunction
endpackage

// ===== src/qmi_ram.sv =====
// Generic single-port write, registered-read RAM.
// No dependencies.
module qmi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/qmi_cell.sv =====
// One multiply-accumulate cell of the chain; forwards control to its neighbor.
// Depends on qmi_pkg.
module qmi_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qmi_pkg::mac_ctl_t    ctl_i,
  input  logic signed [7:0]    a_i,
  input  logic signed [7:0]    b_i,
  output qmi_pkg::mac_ctl_t    ctl_o,
  output logic signed [31:0]   acc_o
);
  import qmi_pkg::*;

  logic signed [15:0] prod_q;
  mac_ctl_t ctl_q;
  logic signed [31:0] acc_q, acc_d;

  // Stage one: product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      ctl_o <= '0;
    end else begin
      ctl_q <= ctl_i;
      ctl_o <= ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  // Stage two: wrapping accumulate, restart on first term
  always_comb begin
    acc_d = acc_q;
    if (ctl_q.valid) begin
      acc_d = (ctl_q.first ? 32'sd0 : acc_q) + 32'(prod_q);
    end
  end

  assign acc_o = acc_q;
endmodule

// ===== src/quantized_mlp_inference_core.sv =====
// Top level of the two-layer int8 perceptron: loads, sequencer, MAC cells, scaler.
// Depends on qmi_pkg, qmi_ram, qmi_cell and the defines header.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries load words and
// sample words; one output channel (out_valid_o / out_stall_i) carries the logit.
// Load words and non-last samples are taken at one per cycle while the input
// is not stalled. A sample with last set starts an inference: a chain of two
// cells runs, the first cell accumulating each hidden neuron over its inputs
// (one MAC per cycle, memory port limited), the second accumulating the output
// neuron. Each hidden neuron goes through its reads, the two-stage MAC and a
// 64-bit scale in two steps; the output neuron then drains, multiplies, rounds
// and loads the logit into the output register.
// The input is stalled during the inference and while a logit waits.
// A stalled logit holds until taken. Reset clears all control and the output
// registers to zero; the tables are undefined until written. The APB port writes
// out_bias, out_multiplier and out_shift at byte addresses 0, 4 and 8.
`include "quantized_mlp_inference_core_defines.svh"
module quantized_mlp_inference_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  neuron_index_i,
  input  logic [3:0]  element_index_i,
  input  logic signed [7:0]  weight_i,
  input  logic signed [31:0] bias_i,
  input  logic signed [31:0] multiplier_i,
  input  logic [4:0]  shift_i,
  input  logic signed [7:0]  sample_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] logit_o
);
  import qmi_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MAC   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_RND   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] out_bias_q, out_mult_q;
  logic [4:0]  out_shift_q;
  logic        in_acc;
  logic [InW:0]  elem_q;
  logic [HidW:0] neur_q;
  logic [2:0]    drain_q;
  logic          out_phase_q;
  logic signed [63:0] prod_q;
  logic        out_valid_q;
  logic signed [31:0] logit_q;

  // Config port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bias_q  <= '0;
      out_mult_q  <= '0;
      out_shift_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_e'(paddr[3:2]))
        REG_OUT_BIAS:  out_bias_q  <= pwdata;
        REG_OUT_MULT:  out_mult_q  <= pwdata;
        REG_OUT_SHIFT: out_shift_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_OUT_BIAS:  prdata = out_bias_q;
      REG_OUT_MULT:  prdata = out_mult_q;
      REG_OUT_SHIFT: prdata = {27'd0, out_shift_q};
      default:       prdata = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign in_acc = in_valid_i && !in_stall_o;

  // Tables
  logic we_hw, we_sb, we_ow, we_hp;
  assign we_hw = in_acc && req_type_i == REQ_HID_WEIGHT;
  assign we_hp = in_acc && req_type_i == REQ_HID_PARAM;
  assign we_ow = in_acc && req_type_i == REQ_OUT_WEIGHT;
  assign we_sb = in_acc && req_type_i == REQ_SAMPLE;

  logic [InW-1:0]  rd_elem;
  logic [HidW-1:0] rd_neur;
  assign rd_elem = elem_q[InW-1:0];
  assign rd_neur = neur_q[HidW-1:0];

  logic [7:0] hw_rd, sb_rd, ow_rd;
  logic [68:0] hp_rd;
  qmi_ram #(.Width(8), .Depth(InputCount * HiddenCount)) u_hw (
    .clk_i, .we_i(we_hw), .waddr_i({neuron_index_i, element_index_i}),
    .wdata_i(weight_i), .raddr_i({rd_neur, rd_elem}), .rdata_o(hw_rd));
  qmi_ram #(.Width(8), .Depth(InputCount)) u_sb (
    .clk_i, .we_i(we_sb), .waddr_i(element_index_i), .wdata_i(sample_i),
    .raddr_i(rd_elem), .rdata_o(sb_rd));
  qmi_ram #(.Width(8), .Depth(HiddenCount)) u_ow (
    .clk_i, .we_i(we_ow), .waddr_i(element_index_i), .wdata_i(weight_i),
    .raddr_i(rd_neur), .rdata_o(ow_rd));
  qmi_ram #(.Width(69), .Depth(HiddenCount)) u_hp (
    .clk_i, .we_i(we_hp), .waddr_i(neuron_index_i),
    .wdata_i({bias_i, multiplier_i, shift_i}), .raddr_i(rd_neur), .rdata_o(hp_rd));

  // Issue control for the hidden cell, one read per cycle
  logic issue_q;
  logic first_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      issue_q <= (state_q == ST_MAC);
      first_q <= (state_q == ST_MAC) && elem_q == '0;
    end
  end

  mac_ctl_t c0_in, c0_out, c1_out, c1_in;
  logic signed [31:0] hacc, oacc;
  logic [2:0] act_q;
  assign c0_in = '{valid: issue_q, first: first_q, idx: '0};

  qmi_cell u_cell_h (.clk_i, .rst_ni, .ctl_i(c0_in), .a_i(sb_rd), .b_i(hw_rd),
    .ctl_o(c0_out), .acc_o(hacc));

  // Output cell takes one activation per hidden neuron
  logic act_v_q, act_first_q;
  assign c1_in = '{valid: act_v_q, first: act_first_q, idx: c0_out.idx};
  qmi_cell u_cell_o (.clk_i, .rst_ni, .ctl_i(c1_in), .a_i({5'd0, act_q}), .b_i(ow_rd),
    .ctl_o(c1_out), .acc_o(oacc));

  // Scaler operands
  logic signed [31:0] sc_acc, sc_mul;
  logic [4:0] sc_sh;
  logic [31:0] sc_res;
  always_comb begin
    if (out_phase_q) begin
      sc_acc = oacc + out_bias_q;
      sc_mul = out_mult_q;
      sc_sh  = out_shift_q;
    end else begin
      sc_acc = hacc + hp_rd[68:37];
      sc_mul = hp_rd[36:5];
      sc_sh  = hp_rd[4:0];
    end
  end
  assign sc_res = round_shift(prod_q, sc_sh);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && req_type_i == REQ_SAMPLE && last_i) state_d = ST_MAC;
      ST_MAC:   if (elem_q == (InW+1)'(InputCount - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q == 3'd4) state_d = ST_MUL;
      ST_MUL:   state_d = ST_RND;
      ST_RND: begin
        if (out_phase_q) state_d = ST_OUT;
        else if (neur_q == (HidW+1)'(HiddenCount - 1)) state_d = ST_DRAIN;
        else state_d = ST_MAC;
      end
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      elem_q <= '0;
      neur_q <= '0;
      drain_q <= '0;
      out_phase_q <= 1'b0;
      act_v_q <= 1'b0;
      act_first_q <= 1'b0;
      out_valid_q <= 1'b0;
      logit_q <= '0;
    end else begin
      state_q <= state_d;
      act_v_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          elem_q <= '0;
          neur_q <= '0;
          out_phase_q <= 1'b0;
          drain_q <= '0;
        end
        ST_MAC: begin
          elem_q <= elem_q + 1'b1;
          drain_q <= '0;
        end
        ST_DRAIN: drain_q <= drain_q + 1'b1;
        ST_MUL: ;
        ST_RND: begin
          elem_q <= '0;
          drain_q <= '0;
          if (!out_phase_q) begin
            act_v_q <= 1'b1;
            act_first_q <= (neur_q == '0);
            if (neur_q == (HidW+1)'(HiddenCount - 1)) out_phase_q <= 1'b1;
            else neur_q <= neur_q + 1'b1;
          end
        end
        ST_OUT: begin
          out_valid_q <= 1'b1;
          logit_q <= sc_res;
        end
        default: ;
      endcase
    end
  end

  // Product register and clamped activation
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) prod_q <= sc_acc * sc_mul;
    if (state_q == ST_RND && !out_phase_q) begin
      if ($signed(sc_res) < 0) act_q <= 3'd0;
      else if ($signed(sc_res) > 32'sd7) act_q <= ActMax;
      else act_q <= sc_res[2:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign logit_o = logit_q;

  `QMI_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != ST_IDLE) |-> in_stall_o,
    "input accepted during inference")
  `QMI_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(logit_o),
    "logit changed while stalled")
  `QMI_ASSERT_NEVER(a_out_busy, clk_i, rst_ni, (state_q == ST_OUT) && out_valid_q,
    "new logit over an untaken one")
  `QMI_ASSERT(a_act_window, clk_i, rst_ni,
    c1_out.valid |-> (state_q == ST_MAC || state_q == ST_DRAIN),
    "output cell word outside the accumulate window")
endmodule

// ===== verif/tb_quantized_mlp_inference_core.sv =====
// Self-checking testbench for the quantized two-layer int8 perceptron core.
// Loads tables, streams frames of samples and checks each logit against a
// local model. Depends on qmi_pkg and quantized_mlp_inference_core.
module tb_quantized_mlp_inference_core;
  timeunit 1ns;
  timeprecision 1ps;
  import qmi_pkg::*;

  localparam int NumIn = 16;
  localparam int NumHid = 16;
  localparam int StallLimit = 20000;

  // Logit model: holds tables, config and the queue of pending logits
  class logit_scoreboard;
    logic signed [7:0]  hid_wt [NumHid][NumIn];
    logic signed [31:0] hid_bias [NumHid];
    logic signed [31:0] hid_mult [NumHid];
    logic [4:0]         hid_shift [NumHid];
    logic signed [7:0]  out_wt [NumHid];
    logic signed [7:0]  samples [NumIn];
    logic signed [31:0] cfg_bias;
    logic signed [31:0] cfg_mult;
    logic [4:0]         cfg_shift;
    logic signed [31:0] pending_logits [$];
    int errors;

    function void clear();
      cfg_bias = 0;
      cfg_mult = 0;
      cfg_shift = 0;
      errors = 0;
      pending_logits.delete();
    endfunction

    function logic signed [31:0] rescale(logic signed [31:0] acc,
                                         logic signed [31:0] m, logic [4:0] s);
      logic signed [63:0] prod;
      logic signed [63:0] sum;
      prod = 64'(acc) * 64'(m);
      sum = prod + (64'sd1 <<< (30 + s));
      sum = sum >>> (31 + s);
      return sum[31:0];
    endfunction

    function logic signed [31:0] evaluate();
      logic signed [31:0] acc;
      logic signed [31:0] act;
      logic signed [31:0] hid [NumHid];
      for (int o = 0; o < NumHid; o++) begin
        acc = hid_bias[o];
        for (int i = 0; i < NumIn; i++) acc += 32'(samples[i]) * 32'(hid_wt[o][i]);
        act = rescale(acc, hid_mult[o], hid_shift[o]);
        if (act < 0) act = 0;
        if (act > 7) act = 7;
        hid[o] = act;
      end
      acc = cfg_bias;
      for (int o = 0; o < NumHid; o++) acc += hid[o] * 32'(out_wt[o]);
      return rescale(acc, cfg_mult, cfg_shift);
    endfunction

    function void note_word(req_e t, logic [3:0] ni, logic [3:0] ei,
                            logic signed [7:0] w, logic signed [31:0] b,
                            logic signed [31:0] m, logic [4:0] s,
                            logic signed [7:0] smp, logic lst);
      case (t)
        REQ_HID_WEIGHT: hid_wt[ni][ei] = w;
        REQ_HID_PARAM: begin
          hid_bias[ni] = b;
          hid_mult[ni] = m;
          hid_shift[ni] = s;
        end
        REQ_OUT_WEIGHT: out_wt[ei] = w;
        default: begin
          samples[ei] = smp;
          if (lst) pending_logits.push_back(evaluate());
        end
      endcase
    endfunction

    function void check_logit(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending_logits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected logit %0d", got);
        return;
      end
      want = pending_logits.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("logit mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] req_type = 0;
  logic [3:0] neuron_index = 0, element_index = 0;
  logic signed [7:0] weight = 0, sample = 0;
  logic signed [31:0] bias = 0, multiplier = 0;
  logic [4:0] shift = 0;
  logic last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] logit;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  logit_scoreboard sb;

  quantized_mlp_inference_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .neuron_index_i(neuron_index),
    .element_index_i(element_index), .weight_i(weight), .bias_i(bias),
    .multiplier_i(multiplier), .shift_i(shift), .sample_i(sample),
    .last_i(last), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .logit_o(logit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Check logits and drive receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_logit(logit);
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run after a long stretch with no word accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_e r, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= 4'(r) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (r)
      REG_OUT_BIAS: sb.cfg_bias = val;
      REG_OUT_MULT: sb.cfg_mult = val;
      default: sb.cfg_shift = val[4:0];
    endcase
  endtask

  // Offer one word, hold it until accepted, then note it; valid drops only
  // in idle gaps and when the sender pauses
  task automatic send_word(req_e t, logic [3:0] ni, logic [3:0] ei,
                           logic signed [7:0] w, logic signed [31:0] b,
                           logic signed [31:0] m, logic [4:0] s,
                           logic signed [7:0] smp, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    req_type <= t;
    neuron_index <= ni;
    element_index <= ei;
    weight <= w;
    bias <= b;
    multiplier <= m;
    shift <= s;
    sample <= smp;
    last <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_word(t, ni, ei, w, b, m, s, smp, lst);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed(8'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  // Load the whole network with random content; extremes now and then
  task automatic load_network();
    for (int o = 0; o < NumHid; o++) begin
      send_word(REQ_HID_PARAM, 4'(o), 4'($urandom), 8'($urandom),
                32'($signed(16'($urandom))), rand_word(), 5'($urandom_range(12)),
                8'($urandom), 1'($urandom));
      for (int i = 0; i < NumIn; i++)
        send_word(REQ_HID_WEIGHT, 4'(o), 4'(i), 8'($urandom), $urandom, $urandom,
                  5'($urandom), 8'($urandom), 1'($urandom));
      send_word(REQ_OUT_WEIGHT, 4'($urandom), 4'(o), 8'($urandom), $urandom,
                $urandom, 5'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // Send a frame of samples, the last marked; occasionally rewrite a weight or hidden parameter
  task automatic send_frame();
    for (int i = 0; i < NumIn; i++) begin
      if ($urandom_range(9) == 0)
        send_word(req_e'($urandom_range(2)), 4'($urandom), 4'($urandom),
                  8'($urandom), $urandom, $urandom, 5'($urandom_range(12)),
                  8'($urandom), 1'($urandom));
      send_word(REQ_SAMPLE, 4'($urandom), 4'(i), 8'($urandom), $urandom,
                $urandom, 5'($urandom), 8'($urandom), i == NumIn - 1);
    end
    if ($urandom_range(3) == 0)
      send_word(REQ_SAMPLE, 4'($urandom), 4'($urandom), 8'($urandom), $urandom,
                $urandom, 5'($urandom), 8'($urandom), 1'b1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_logits.size() != 0) @(negedge clk);
    repeat (450) @(negedge clk);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(negedge clk);
    rst_n <= 1;

    // Directed: fixed extremes for the output config and a full frame
    write_reg(REG_OUT_BIAS, 32'h7fff_ffff);
    write_reg(REG_OUT_MULT, 32'h8000_0000);
    write_reg(REG_OUT_SHIFT, 5'd31);
    load_network();
    send_word(REQ_HID_PARAM, 4'd15, 4'd0, 8'sd0, 32'h8000_0000, 32'h7fff_ffff,
              5'd31, 8'sd0, 1'b1);
    for (int i = 0; i < NumIn; i++)
      send_word(REQ_SAMPLE, 4'd0, 4'(i), 8'sd0, 0, 0, 5'd0,
                (i % 2) ? 8'sh80 : 8'sh7f, i == NumIn - 1);
    send_word(REQ_SAMPLE, 4'd0, 4'd15, 8'sd0, 0, 0, 5'd0, 8'sh80, 1'b1);
    drain();

    // Random phases with varying config, sender idling and receiver stalls; frames rewrite weights
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 52; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 52; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      write_reg(REG_OUT_BIAS, rand_word());
      write_reg(REG_OUT_MULT, ph == 7 ? 32'h7fff_ffff : rand_word());
      write_reg(REG_OUT_SHIFT, ph == 6 ? 5'd0 : 5'($urandom_range(10)));
      for (int f = 0; f < 4; f++) begin
        if (ph == 2 && f == 1) begin
          // Hold the receiver off while frames keep coming
          fork
            begin
              hold_off = 1;
              repeat (2000) @(negedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_frame();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
